@@ rtl/core/tscl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscl_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package tscl_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int X_W           = 32;
  localparam int TC_W          = 6;
  localparam int K_W           = 7;
  localparam int MAG_W         = 64;
  localparam int ACC_W         = 64;
  localparam int STAT_W        = 2;
  localparam int REQ_W         = 2;

  localparam logic [TC_W-1:0]  TC_RESET = 6'd8;
  localparam logic [MAG_W-1:0] TERM_CAP = 64'h0100_0000_0000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_COS = 2'd0,
    REQ_SIN = 2'd1,
    REQ_LN  = 2'd2,
    REQ_BAD = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_SAT    = 2'd1,
    ST_DOMAIN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_X2,
    CMD_SET_X2,
    CMD_DIV_C,
    CMD_SET_C,
    CMD_MUL_T,
    CMD_DIV_T,
    CMD_ACC,
    CMD_ACC_ONE,
    CMD_EMIT_SUM,
    CMD_EMIT_SAT,
    CMD_EMIT_DOM
  } cmd_t;

  typedef struct packed {
    cmd_t           op;
    logic [K_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    req_t sel;
    logic domain;
    logic mul_done;
    logic div_done;
    logic term_ovf;
    logic c_big;
  } dp_stat_t;

endpackage

@@ rtl/core/tscl_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscl_mul
// fixed-point magnitude multiplier, four 32x32 partial products, one per cycle
// ----------------------------------------------------------------------------
module tscl_mul import tscl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  output logic             done,
  output logic [MAG_W-1:0] r,
  output logic             ovf
);

  logic [MAG_W-1:0]   a_r, b_r;
  logic [2*MAG_W-1:0] prod_r, prod_nxt, pp_sh;
  logic [1:0]         step_r;
  logic               busy_r, done_r;
  logic [31:0]        ma, mb;
  logic [63:0]        pp;
  logic [MAG_W-1:0]   slice;

  always_comb begin
    case (step_r)
      2'd0: begin
        ma = a_r[31:0];  mb = b_r[31:0];
      end
      2'd1: begin
        ma = a_r[31:0];  mb = b_r[63:32];
      end
      2'd2: begin
        ma = a_r[63:32]; mb = b_r[31:0];
      end
      default: begin
        ma = a_r[63:32]; mb = b_r[63:32];
      end
    endcase
    pp = ma * mb;
    case (step_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    prod_nxt = prod_r + pp_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign slice = prod_r[MAG_W-1+FRAC_BITS:FRAC_BITS];
  assign ovf   = (|prod_r[2*MAG_W-1:MAG_W+FRAC_BITS]) || (slice > TERM_CAP);
  assign r     = ovf ? TERM_CAP : slice;
  assign done  = done_r;

endmodule

@@ rtl/core/tscl_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscl_div
// restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module tscl_div import tscl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [MAG_W-1:0] quot
);

  logic [MAG_W-1:0] q_r;
  logic [31:0]      rem_r, d_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [32:0]      rem_sh;
  logic [33:0]      diff;

  assign rem_sh = {rem_r, q_r[MAG_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_r <= diff[31:0];
        q_r   <= {q_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r   <= {q_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ rtl/core/tscl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscl_dp
// series datapath: argument, term and sum registers, multiplier and divider
// ----------------------------------------------------------------------------
module tscl_dp import tscl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic signed [X_W-1:0] in_x_value,
  output logic signed [X_W-1:0] out_result_value,
  output logic [STAT_W-1:0] out_status
);

  localparam logic [MAG_W-1:0] ONE_FX = MAG_W'(1) << FRAC_BITS;

  req_t                    sel_r;
  logic [X_W-1:0]          ax_r;
  logic                    xneg_r, cneg_r, x2o_r;
  logic [MAG_W-1:0]        x2_r, t_r, c_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [X_W-1:0]          res_r;
  status_t                 stat_r;

  logic [X_W-1:0]          ax_in;
  logic signed [ACC_W-1:0] diff;
  logic [MAG_W-1:0]        adiff;
  logic                    neg;
  logic [K_W:0]            k2;
  logic [2*K_W+1:0]        dsc;
  logic                    mul_start, div_start;
  logic [MAG_W-1:0]        mul_a, mul_b, mul_r, div_n, div_q;
  logic [31:0]             div_d;
  logic                    mul_done, mul_ovf, div_done;
  logic signed [ACC_W-1:0] q_s;

  assign ax_in = in_x_value[X_W-1] ? (~in_x_value + 1'b1) : in_x_value;
  assign diff  = $signed({{(ACC_W-X_W){1'b0}}, ax_r}) - $signed(ONE_FX);
  assign adiff = (diff < 0) ? MAG_W'(-diff) : MAG_W'(diff);
  assign k2    = {cmd.k, 1'b0};

  always_comb begin
    case (sel_r)
      REQ_COS: neg = cmd.k[0];
      REQ_SIN: neg = xneg_r ^ cmd.k[0];
      default: neg = cneg_r & cmd.k[0];
    endcase
    case (sel_r)
      REQ_COS: dsc = (k2 - 1'b1) * k2;
      REQ_SIN: dsc = k2 * (k2 + 1'b1);
      default: dsc = {{(K_W+2){1'b0}}, cmd.k};
    endcase
  end

  assign mul_start = (cmd.op == CMD_MUL_X2) || (cmd.op == CMD_MUL_T);
  assign mul_a     = (cmd.op == CMD_MUL_X2) ? {{(MAG_W-X_W){1'b0}}, ax_r} : t_r;
  assign mul_b     = (cmd.op == CMD_MUL_X2) ? {{(MAG_W-X_W){1'b0}}, ax_r} :
                     (sel_r == REQ_LN) ? c_r : x2_r;
  assign div_start = (cmd.op == CMD_DIV_C) || (cmd.op == CMD_DIV_T);
  assign div_n     = (cmd.op == CMD_DIV_C) ? (adiff << FRAC_BITS) : mul_r;
  assign div_d     = (cmd.op == CMD_DIV_C) ? ax_r : 32'(dsc);
  assign q_s       = neg ? -$signed(div_q) : $signed(div_q);

  tscl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .r(mul_r), .ovf(mul_ovf)
  );

  tscl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
    .divisor(div_d), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= ST_OK;
      res_r  <= '0;
    end else begin
      case (cmd.op)
        CMD_LOAD: begin
          sel_r  <= req_t'(in_req_type);
          ax_r   <= ax_in;
          xneg_r <= in_x_value[X_W-1];
          t_r    <= (req_t'(in_req_type) == REQ_SIN) ? {{(MAG_W-X_W){1'b0}}, ax_in} : ONE_FX;
          acc_r  <= (req_t'(in_req_type) == REQ_SIN) ? ACC_W'(in_x_value) : '0;
        end
        CMD_SET_X2: begin
          x2_r  <= mul_r;
          x2o_r <= mul_ovf;
        end
        CMD_DIV_C: cneg_r <= (diff < 0);
        CMD_SET_C: c_r <= div_q;
        CMD_DIV_T: if (sel_r == REQ_LN) t_r <= mul_r;
        CMD_ACC: begin
          if (sel_r != REQ_LN) t_r <= div_q;
          acc_r <= acc_r + q_s;
        end
        CMD_ACC_ONE: acc_r <= acc_r + $signed(ONE_FX);
        CMD_EMIT_SUM: begin
          if (acc_r > $signed(ACC_W'(32'sh7FFF_FFFF))) begin
            res_r <= 32'h7FFF_FFFF; stat_r <= ST_SAT;
          end else if (acc_r < -$signed(ACC_W'(33'h0_8000_0000))) begin
            res_r <= 32'h8000_0000; stat_r <= ST_SAT;
          end else begin
            res_r <= acc_r[X_W-1:0]; stat_r <= ST_OK;
          end
        end
        CMD_EMIT_SAT: begin
          res_r  <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          stat_r <= ST_SAT;
        end
        CMD_EMIT_DOM: begin
          res_r  <= '0;
          stat_r <= ST_DOMAIN;
        end
        default: ;
      endcase
    end
  end

  assign stat.sel      = sel_r;
  assign stat.domain   = (sel_r == REQ_BAD) || ((sel_r == REQ_LN) && (xneg_r || ax_r == '0));
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.term_ovf = mul_ovf || ((sel_r != REQ_LN) && x2o_r);
  assign stat.c_big    = c_r > TERM_CAP;

  assign out_result_value = res_r;
  assign out_status       = stat_r;

endmodule

@@ rtl/core/tscl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscl_ctrl
// sequencer: term loop, term-count register and handshakes
// ----------------------------------------------------------------------------
module tscl_ctrl import tscl_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [TC_W-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output dp_cmd_t         cmd,
  input  dp_stat_t        stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_WX2, S_ACC1, S_WC, S_CCHK,
    S_TERM, S_WM, S_WD, S_SUM, S_SAT, S_DOM
  } state_t;

  state_t          state_r, state_nxt;
  logic [K_W-1:0]  k_r, k_nxt, n;
  logic [TC_W-1:0] tc_r;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free, loop_end, emit;
  cmd_t            op;

  assign n = ({1'b0, tc_r} > 7'(MAX_TERMS)) ? K_W'(MAX_TERMS) : K_W'(tc_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign loop_end  = (stat.sel == REQ_COS) ? (k_r >= n) : (k_r > n);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    op        = CMD_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        op = CMD_LOAD; state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.domain) state_nxt = S_DOM;
        else if (stat.sel == REQ_LN) begin
          op = CMD_DIV_C; state_nxt = S_WC;
        end else if (n == '0) state_nxt = S_SUM;
        else begin
          op = CMD_MUL_X2; state_nxt = S_WX2;
        end
      end
      S_WX2: if (stat.mul_done) begin
        op = CMD_SET_X2;
        if (stat.sel == REQ_COS) begin
          k_nxt = '0; state_nxt = S_ACC1;
        end else begin
          k_nxt = K_W'(1); state_nxt = S_TERM;
        end
      end
      S_ACC1: begin
        op = CMD_ACC_ONE; k_nxt = K_W'(1); state_nxt = S_TERM;
      end
      S_WC: if (stat.div_done) begin
        op = CMD_SET_C; k_nxt = K_W'(1); state_nxt = S_CCHK;
      end
      S_CCHK: state_nxt = (stat.c_big && n != '0) ? S_SAT : S_TERM;
      S_TERM: begin
        if (loop_end) state_nxt = S_SUM;
        else begin
          op = CMD_MUL_T; state_nxt = S_WM;
        end
      end
      S_WM: if (stat.mul_done) begin
        if (stat.term_ovf) state_nxt = S_SAT;
        else begin
          op = CMD_DIV_T; state_nxt = S_WD;
        end
      end
      S_WD: if (stat.div_done) begin
        op = CMD_ACC; k_nxt = k_r + 1'b1; state_nxt = S_TERM;
      end
      S_SUM: if (slot_free) begin
        op = CMD_EMIT_SUM; state_nxt = S_IDLE;
      end
      S_SAT: if (slot_free) begin
        op = CMD_EMIT_SAT; state_nxt = S_IDLE;
      end
      S_DOM: if (slot_free) begin
        op = CMD_EMIT_DOM; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign emit = (op == CMD_EMIT_SUM) || (op == CMD_EMIT_SAT) || (op == CMD_EMIT_DOM);
  assign out_valid_nxt = (out_valid_r && out_stall) || emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      tc_r        <= TC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) tc_r <= cfg_wr_data;
    end
  end

  assign cmd.op    = op;
  assign cmd.k     = k_r;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/taylor_series_cos_sin_ln.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_series_cos_sin_ln
// cosine, sine and natural log by series summation in signed fixed point
// per term: a multiply by x^2 (or by c for log), then a serial divide, then
//   accumulation; no terms are computed when the term count is zero or on a
//   domain error
// throughput: one item at a time, next item taken once the result is stored
// reset: synchronous active-low, term count returns to 8, no item in flight
// ----------------------------------------------------------------------------
module taylor_series_cos_sin_ln import tscl_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [TC_W-1:0]       cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic signed [X_W-1:0] in_x_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [X_W-1:0] out_result_value,
  output logic [STAT_W-1:0]     out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tscl_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  tscl_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_req_type(in_req_type), .in_x_value(in_x_value),
    .out_result_value(out_result_value), .out_status(out_status)
  );

endmodule
